/* rtl/rcss_pkg.sv */
// Shared types and constants for the range count square sum window block.
`default_nettype none

package rcss_pkg;

   // Default sizes of the two stores
   localparam int ArrayDepthDef = 65536;
   localparam int ValueCountDef = 1024;

   // Fixed field widths
   localparam int POS_W = 17;
   localparam int VAL_W = 10;
   localparam int CNT_W = 17;
   localparam int SUM_W = 33;

   // Request opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // Histogram update operations
   typedef enum logic [0:0] {
      HIST_INC,
      HIST_DEC
   } hist_op_type;

   // Command from the controller to the histogram unit
   typedef struct packed {
      logic              valid;
      hist_op_type       op;
      logic [VAL_W-1:0]  value;
   } hist_cmd_type;

   // Controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LD_ELEM,
      ST_LD_DEC,
      ST_LD_INC,
      ST_LD_DONE,
      ST_WALK,
      ST_STEP_ELEM,
      ST_STEP_HIST
   } ctrl_state_type;

endpackage

`default_nettype wire

/* rtl/rcss_elem_mem.sv */
// Single-port element store with registered read data.
`default_nettype none

module rcss_elem_mem #(
   parameter int  DEPTH = rcss_pkg::ArrayDepthDef,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       en,
   input  wire logic                       we,
   input  wire logic [AW-1:0]              addr,
   input  wire logic [rcss_pkg::VAL_W-1:0] wdata,
   output logic      [rcss_pkg::VAL_W-1:0] rdata
);

   logic [rcss_pkg::VAL_W-1:0] elem_mem [DEPTH];
   logic [rcss_pkg::VAL_W-1:0] rdata_ff;

   // Write or read one entry a cycle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            elem_mem[addr] <= wdata;
         end else begin
            rdata_ff <= elem_mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* rtl/rcss_hist.sv */
// Value histogram memory with read-modify-write of counts and the running sum.
`default_nettype none

module rcss_hist #(
   parameter int  VALUE_COUNT = rcss_pkg::ValueCountDef,
   localparam int VW          = $clog2(VALUE_COUNT)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire rcss_pkg::hist_cmd_type     cmd,
   input  wire logic                       clr_we,
   input  wire logic [VW-1:0]              clr_addr,
   output logic      [rcss_pkg::SUM_W-1:0] sum
);

   logic [rcss_pkg::CNT_W-1:0] count_mem [VALUE_COUNT];
   logic [rcss_pkg::CNT_W-1:0] count_rd_ff;
   logic [VW-1:0]              idx_ff;
   rcss_pkg::hist_op_type      op_ff;
   logic                       pend_ff;
   logic [rcss_pkg::SUM_W-1:0] sum_ff;
   logic [rcss_pkg::SUM_W-1:0] sum_in;
   logic [rcss_pkg::CNT_W-1:0] count_in;
   logic                       count_we;
   logic [rcss_pkg::SUM_W-1:0] inc_amt;
   logic [rcss_pkg::SUM_W-1:0] dec_amt;

   // Read the count on a command, write it back in the following cycle; clear sweep takes priority
   always_ff @(posedge clock) begin
      if (cmd.valid) begin
         count_rd_ff <= count_mem[VW'(cmd.value)];
         idx_ff      <= VW'(cmd.value);
         op_ff       <= cmd.op;
      end
      if (clr_we) begin
         count_mem[clr_addr] <= '0;
      end else if (count_we) begin
         count_mem[idx_ff] <= count_in;
      end
   end

   // Track the pending update and hold the running sum
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
         sum_ff  <= '0;
      end else begin
         pend_ff <= cmd.valid;
         sum_ff  <= sum_in;
      end
   end

   // Square-sum deltas: (c+1)^2 - c^2 and c^2 - (c-1)^2
   assign inc_amt = rcss_pkg::SUM_W'({count_rd_ff, 1'b1});
   assign dec_amt = rcss_pkg::SUM_W'({count_rd_ff, 1'b0}) - rcss_pkg::SUM_W'(1);

   // Apply the update; removal saturates count and sum at zero
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_rd_ff;
      count_we = 1'b0;
      if (pend_ff) begin
         unique case (op_ff)
            rcss_pkg::HIST_INC: begin
               sum_in   = sum_ff + inc_amt;
               count_in = count_rd_ff + rcss_pkg::CNT_W'(1);
               count_we = 1'b1;
            end
            rcss_pkg::HIST_DEC: begin
               if (count_rd_ff != '0) begin
                  sum_in   = (sum_ff >= dec_amt) ? (sum_ff - dec_amt) : '0;
                  count_in = count_rd_ff - rcss_pkg::CNT_W'(1);
                  count_we = 1'b1;
               end
            end
            default: begin
               count_we = 1'b0;
            end
         endcase
      end
   end

   assign sum = sum_ff;

`ifndef ASSERT_OFF
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      cmd.valid |-> !pend_ff)
      else $error("histogram command issued while an update is pending");

   a_clear_alone: assert property (@(posedge clock) disable iff (reset)
      clr_we |-> (!cmd.valid && !pend_ff))
      else $error("histogram clear overlaps an update");

   a_inc_moves_sum: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && op_ff == rcss_pkg::HIST_INC) |=> (sum_ff != $past(sum_ff)))
      else $error("count increment left the running sum unchanged");
`endif

endmodule

`default_nettype wire

/* rtl/rcss_ctrl.sv */
// Controller: clearing sweep, load handling, window walk and result register.
`default_nettype none

module rcss_ctrl #(
   parameter int  ARRAY_DEPTH = rcss_pkg::ArrayDepthDef,
   parameter int  VALUE_COUNT = rcss_pkg::ValueCountDef,
   localparam int AW          = $clog2(ARRAY_DEPTH),
   localparam int VW          = $clog2(VALUE_COUNT)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_opcode,
   input  wire logic [rcss_pkg::POS_W-1:0] req_position,
   input  wire logic [rcss_pkg::VAL_W-1:0] req_element_value,
   input  wire logic [rcss_pkg::POS_W-1:0] req_left_end,
   input  wire logic [rcss_pkg::POS_W-1:0] req_right_end,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [rcss_pkg::POS_W-1:0] csr_array_length,
   output logic                            rsp_valid,
   output logic      [rcss_pkg::SUM_W-1:0] rsp_squared_count_sum,
   output logic                            rsp_query_error,
   output logic                            elem_en,
   output logic                            elem_we,
   output logic      [AW-1:0]              elem_addr,
   output logic      [rcss_pkg::VAL_W-1:0] elem_wdata,
   input  wire logic [rcss_pkg::VAL_W-1:0] elem_rdata,
   output rcss_pkg::hist_cmd_type          hist_cmd,
   output logic                            hist_clr_we,
   output logic      [VW-1:0]              hist_clr_addr,
   input  wire logic [rcss_pkg::SUM_W-1:0] hist_sum
);

   localparam int MaxDepth = (ARRAY_DEPTH > VALUE_COUNT) ? ARRAY_DEPTH : VALUE_COUNT;
   localparam int CLR_W    = $clog2(MaxDepth);
   localparam logic [CLR_W-1:0] ClrLast = CLR_W'(MaxDepth - 1);

   rcss_pkg::ctrl_state_type   state_ff, state_in;
   logic [CLR_W-1:0]           clr_cnt_ff, clr_cnt_in;
   logic [rcss_pkg::POS_W-1:0] wl_ff, wl_in;
   logic [rcss_pkg::POS_W-1:0] wr_ff, wr_in;
   logic [rcss_pkg::POS_W-1:0] lq_ff, lq_in;
   logic [rcss_pkg::POS_W-1:0] rq_ff, rq_in;
   logic [rcss_pkg::POS_W-1:0] len_ff;
   logic [rcss_pkg::VAL_W-1:0] ld_val_ff, ld_val_in;
   logic [AW-1:0]              ld_addr_ff, ld_addr_in;
   rcss_pkg::hist_op_type      step_op_ff, step_op_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [rcss_pkg::SUM_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                       rsp_err_ff, rsp_err_in;

   logic                       accept;
   logic                       load_ok;
   logic                       load_hit;
   logic                       query_bad;
   logic                       grow_left, grow_right, shrink_left, shrink_right;
   logic                       walk_done;
   logic [rcss_pkg::POS_W-1:0] step_pos;
   logic [AW-1:0]              step_addr;
   logic [AW-1:0]              req_addr;

   assign busy      = (state_ff != rcss_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Request checks
   assign load_ok   = (req_position != '0) && (32'(req_position) <= ARRAY_DEPTH)
                      && (32'(req_element_value) < VALUE_COUNT);
   assign load_hit  = (req_position >= wl_ff) && (req_position <= wr_ff);
   assign query_bad = (req_left_end == '0) || (req_left_end > req_right_end)
                      || (req_right_end > len_ff) || (32'(req_right_end) > ARRAY_DEPTH);
   assign req_addr  = AW'(req_position - rcss_pkg::POS_W'(1));

   // Window walk: grow first, then shrink, one position per step
   assign grow_left    = (wl_ff > lq_ff);
   assign grow_right   = (wr_ff < rq_ff);
   assign shrink_left  = (wl_ff < lq_ff);
   assign shrink_right = (wr_ff > rq_ff);
   assign walk_done    = !(grow_left || grow_right || shrink_left || shrink_right);

   always_comb begin
      if (grow_left) begin
         step_pos = wl_ff - rcss_pkg::POS_W'(1);
      end else if (grow_right) begin
         step_pos = wr_ff + rcss_pkg::POS_W'(1);
      end else if (shrink_left) begin
         step_pos = wl_ff;
      end else begin
         step_pos = wr_ff;
      end
   end

   assign step_addr = AW'(step_pos - rcss_pkg::POS_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rcss_pkg::ST_CLEAR: begin
            if (clr_cnt_ff == ClrLast) state_in = rcss_pkg::ST_IDLE;
         end
         rcss_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == rcss_pkg::OP_LOAD) begin
                  if (load_ok && load_hit) state_in = rcss_pkg::ST_LD_ELEM;
               end else if (!query_bad) begin
                  state_in = rcss_pkg::ST_WALK;
               end
            end
         end
         rcss_pkg::ST_LD_ELEM:   state_in = rcss_pkg::ST_LD_DEC;
         rcss_pkg::ST_LD_DEC:    state_in = rcss_pkg::ST_LD_INC;
         rcss_pkg::ST_LD_INC:    state_in = rcss_pkg::ST_LD_DONE;
         rcss_pkg::ST_LD_DONE:   state_in = rcss_pkg::ST_IDLE;
         rcss_pkg::ST_WALK: begin
            state_in = walk_done ? rcss_pkg::ST_IDLE : rcss_pkg::ST_STEP_ELEM;
         end
         rcss_pkg::ST_STEP_ELEM: state_in = rcss_pkg::ST_STEP_HIST;
         rcss_pkg::ST_STEP_HIST: state_in = rcss_pkg::ST_WALK;
         default:                state_in = rcss_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath next values
   always_comb begin
      clr_cnt_in     = clr_cnt_ff;
      wl_in          = wl_ff;
      wr_in          = wr_ff;
      lq_in          = lq_ff;
      rq_in          = rq_ff;
      ld_val_in      = ld_val_ff;
      ld_addr_in     = ld_addr_ff;
      step_op_in     = step_op_ff;
      rsp_valid_in   = 1'b0;
      rsp_sum_in     = rsp_sum_ff;
      rsp_err_in     = rsp_err_ff;
      elem_en        = 1'b0;
      elem_we        = 1'b0;
      elem_addr      = req_addr;
      elem_wdata     = req_element_value;
      hist_cmd.valid = 1'b0;
      hist_cmd.op    = rcss_pkg::HIST_INC;
      hist_cmd.value = elem_rdata;
      hist_clr_we    = 1'b0;
      hist_clr_addr  = clr_cnt_ff[VW-1:0];
      unique case (state_ff)
         rcss_pkg::ST_CLEAR: begin
            // Sweep both stores to zero
            clr_cnt_in  = clr_cnt_ff + CLR_W'(1);
            elem_en     = (32'(clr_cnt_ff) < ARRAY_DEPTH);
            elem_we     = 1'b1;
            elem_addr   = clr_cnt_ff[AW-1:0];
            elem_wdata  = '0;
            hist_clr_we = (32'(clr_cnt_ff) < VALUE_COUNT);
         end
         rcss_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_opcode == rcss_pkg::OP_LOAD) begin
                  // Outside the window: write at once; inside: fetch the old value first
                  ld_val_in  = req_element_value;
                  ld_addr_in = req_addr;
                  elem_en    = load_ok;
                  elem_we    = !load_hit;
               end else if (query_bad) begin
                  rsp_valid_in = 1'b1;
                  rsp_sum_in   = '0;
                  rsp_err_in   = 1'b1;
               end else begin
                  lq_in = req_left_end;
                  rq_in = req_right_end;
               end
            end
         end
         rcss_pkg::ST_LD_ELEM: begin
            // Drop the old value's count and store the new value
            hist_cmd.valid = 1'b1;
            hist_cmd.op    = rcss_pkg::HIST_DEC;
            elem_en        = 1'b1;
            elem_we        = 1'b1;
            elem_addr      = ld_addr_ff;
            elem_wdata     = ld_val_ff;
         end
         rcss_pkg::ST_LD_DEC: begin
            hist_cmd.valid = 1'b0;
         end
         rcss_pkg::ST_LD_INC: begin
            // Add the new value's count
            hist_cmd.valid = 1'b1;
            hist_cmd.op    = rcss_pkg::HIST_INC;
            hist_cmd.value = ld_val_ff;
         end
         rcss_pkg::ST_LD_DONE: begin
            hist_cmd.valid = 1'b0;
         end
         rcss_pkg::ST_WALK: begin
            if (walk_done) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = hist_sum;
               rsp_err_in   = 1'b0;
            end else begin
               // Move one window end and fetch the element it passes
               elem_en    = 1'b1;
               elem_addr  = step_addr;
               step_op_in = (grow_left || grow_right) ? rcss_pkg::HIST_INC
                                                      : rcss_pkg::HIST_DEC;
               if (grow_left) begin
                  wl_in = wl_ff - rcss_pkg::POS_W'(1);
               end else if (grow_right) begin
                  wr_in = wr_ff + rcss_pkg::POS_W'(1);
               end else if (shrink_left) begin
                  wl_in = wl_ff + rcss_pkg::POS_W'(1);
               end else begin
                  wr_in = wr_ff - rcss_pkg::POS_W'(1);
               end
            end
         end
         rcss_pkg::ST_STEP_ELEM: begin
            hist_cmd.valid = 1'b1;
            hist_cmd.op    = step_op_ff;
         end
         rcss_pkg::ST_STEP_HIST: begin
            hist_cmd.valid = 1'b0;
         end
         default: begin
            hist_cmd.valid = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcss_pkg::ST_CLEAR;
         clr_cnt_ff   <= '0;
         wl_ff        <= rcss_pkg::POS_W'(1);
         wr_ff        <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wl_ff        <= wl_in;
         wr_ff        <= wr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            len_ff <= csr_array_length;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      lq_ff      <= lq_in;
      rq_ff      <= rq_in;
      ld_val_ff  <= ld_val_in;
      ld_addr_ff <= ld_addr_in;
      step_op_ff <= step_op_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_err_ff <= rsp_err_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_squared_count_sum = rsp_sum_ff;
   assign rsp_query_error       = rsp_err_ff;

`ifndef ASSERT_OFF
   a_err_zero_sum: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_sum_ff == '0))
      else $error("flagged query returned a non-zero sum");

   a_window_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcss_pkg::ST_IDLE) |-> ({1'b0, wl_ff} <= ({1'b0, wr_ff} + 18'd1)))
      else $error("window left end passed right end plus one");

   a_window_matches: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_err_ff) |-> ((wl_ff == lq_ff) && (wr_ff == rq_ff)))
      else $error("query answered before the window reached its range");
`endif

endmodule

`default_nettype wire

/* rtl/range_count_square_sum_window.sv */
// Top level of the windowed sum-of-squared-counts engine.
`default_nettype none

// Holds an array of small values and a histogram of the values inside a window of
// positions, with the sum of squared counts kept up to date. After reset the block
// runs a clearing pass over max(ARRAY_DEPTH, VALUE_COUNT) addresses with busy high;
// array_length writes are taken during it. An item is taken when start is high and
// busy low. A load outside the window, an ignored load and a flagged query leave
// busy low; a load inside the window steps through LD_ELEM, LD_DEC, LD_INC and
// LD_DONE. A valid query moves the two window ends one position per step: each step
// is an element memory read followed by a read-modify-write of the count memory.
// Each result is shown for one cycle with rsp_valid high and must be taken
// then: there is no back-pressure on the result side.
module range_count_square_sum_window #(
   parameter int ARRAY_DEPTH = rcss_pkg::ArrayDepthDef,
   parameter int VALUE_COUNT = rcss_pkg::ValueCountDef
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire logic                       req_opcode,
   input  wire logic [rcss_pkg::POS_W-1:0] req_position,
   input  wire logic [rcss_pkg::VAL_W-1:0] req_element_value,
   input  wire logic [rcss_pkg::POS_W-1:0] req_left_end,
   input  wire logic [rcss_pkg::POS_W-1:0] req_right_end,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [rcss_pkg::POS_W-1:0] csr_array_length,
   output logic                            rsp_valid,
   output logic      [rcss_pkg::SUM_W-1:0] rsp_squared_count_sum,
   output logic                            rsp_query_error
);

   localparam int AW = $clog2(ARRAY_DEPTH);
   localparam int VW = $clog2(VALUE_COUNT);

   logic                       elem_en;
   logic                       elem_we;
   logic [AW-1:0]              elem_addr;
   logic [rcss_pkg::VAL_W-1:0] elem_wdata;
   logic [rcss_pkg::VAL_W-1:0] elem_rdata;
   rcss_pkg::hist_cmd_type     hist_cmd;
   logic                       hist_clr_we;
   logic [VW-1:0]              hist_clr_addr;
   logic [rcss_pkg::SUM_W-1:0] hist_sum;

   // Sequencer
   rcss_ctrl #(
      .ARRAY_DEPTH (ARRAY_DEPTH),
      .VALUE_COUNT (VALUE_COUNT)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_position          (req_position),
      .req_element_value     (req_element_value),
      .req_left_end          (req_left_end),
      .req_right_end         (req_right_end),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_array_length      (csr_array_length),
      .rsp_valid             (rsp_valid),
      .rsp_squared_count_sum (rsp_squared_count_sum),
      .rsp_query_error       (rsp_query_error),
      .elem_en               (elem_en),
      .elem_we               (elem_we),
      .elem_addr             (elem_addr),
      .elem_wdata            (elem_wdata),
      .elem_rdata            (elem_rdata),
      .hist_cmd              (hist_cmd),
      .hist_clr_we           (hist_clr_we),
      .hist_clr_addr         (hist_clr_addr),
      .hist_sum              (hist_sum)
   );

   // Element array
   rcss_elem_mem #(
      .DEPTH (ARRAY_DEPTH)
   ) u_elem_mem (
      .clock (clock),
      .en    (elem_en),
      .we    (elem_we),
      .addr  (elem_addr),
      .wdata (elem_wdata),
      .rdata (elem_rdata)
   );

   // Histogram and running sum
   rcss_hist #(
      .VALUE_COUNT (VALUE_COUNT)
   ) u_hist (
      .clock    (clock),
      .reset    (reset),
      .cmd      (hist_cmd),
      .clr_we   (hist_clr_we),
      .clr_addr (hist_clr_addr),
      .sum      (hist_sum)
   );

endmodule

`default_nettype wire
